// File: rtl/pcpa_pkg.sv
// Package for the per-CPU page allocator: sizes, command and status codes,
// the queue entry type and the queue status group. No dependencies.
package pcpa_pkg;

    localparam int NUM_CPUS    = 8;
    localparam int NUM_PAGES   = 32768;
    localparam int STEAL_LIMIT = 64;
    localparam int PAGE_SHIFT  = 12;

    localparam int ADDR_W   = 32;
    localparam int CPU_W    = 3;
    localparam int PAGE_W   = $clog2(NUM_PAGES);
    localparam int CODE_W   = $clog2(NUM_PAGES + 1);
    localparam int BUDGET_W = $clog2(STEAL_LIMIT + 1);
    localparam int VIC_W    = $clog2(NUM_CPUS + 1);
    localparam int STAT_W   = 2;

    localparam int S_TDATA_W = ((CPU_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDR_W + STAT_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [0:0] REQ_ALLOC = 1'b0;
    localparam logic [0:0] REQ_FREE  = 1'b1;

    localparam logic [0:0] REG_REGION_START = 1'b0;
    localparam logic [0:0] REG_REGION_END   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_BAD   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CPU_W-1:0]  cpu;
        logic [PAGE_W-1:0] page;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: rtl/per_cpu_page_free_list_allocator_top.sv
// Top level of the per-CPU page allocator: configuration registers and
// the front end, command queue and back end. Depends on pcpa_pkg.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser req_type, tdata cpu_id, page_addr
//  m_*      out  m_tvalid/m_tready   tuser granted, tdata alloc_addr, status
//  cfg_*    in   cfg_we              cfg_index, cfg_data
//
// Free and bad free: done in ST_IDLE; allocate from own list: ST_IDLE then
// ST_POP_RD (one link-table read). Steal: ST_STEAL per visited CPU, and
// ST_STEAL then ST_STEAL_RD per moved page, up to STEAL_LIMIT pages, set by
// the read-then-write walk of the single-port link table. Reset empties all
// lists at once; the link table is not cleared.
// The queue keeps taking words, until full, while the back end walks or the result stalls.
module per_cpu_page_free_list_allocator_top
    import pcpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] cpu_id, [34:3] page_addr, rest zero
    input  logic [0:0]           s_tuser,   // [0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] alloc_addr, [33:32] status, rest zero
    output logic [0:0]           m_tuser,   // [0] granted
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    logic [ADDR_W-1:0] region_start_reg;
    logic [ADDR_W-1:0] region_end_reg;

    fifo_stat_t        fifo_stat;
    logic              fifo_push;
    logic              fifo_pop;
    cmd_t              push_cmd;
    cmd_t              head_cmd;

    logic              res_granted;
    logic [ADDR_W-1:0] res_addr;
    logic [STAT_W-1:0] res_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= 32'h8000_0000;
            region_end_reg   <= 32'h8800_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REGION_START: region_start_reg <= cfg_data;
                REG_REGION_END:   region_end_reg   <= cfg_data;
                default:          region_end_reg   <= region_end_reg;
            endcase
        end
    end

    pcpa_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .region_start (region_start_reg),
        .region_end   (region_end_reg),
        .fifo_stat    (fifo_stat),
        .fifo_push    (fifo_push),
        .fifo_cmd     (push_cmd)
    );

    pcpa_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .stat     (fifo_stat)
    );

    pcpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .region_start (region_start_reg),
        .cmd          (head_cmd),
        .fifo_stat    (fifo_stat),
        .fifo_pop     (fifo_pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_granted  (res_granted),
        .res_addr     (res_addr),
        .res_status   (res_status)
    );

    assign m_tdata = {{(M_TDATA_W - ADDR_W - STAT_W){1'b0}}, res_status, res_addr};
    assign m_tuser = res_granted;

endmodule

// File: rtl/pcpa_front.sv
// Front end: takes request words and classifies them as allocate, good free
// or bad free, with the page index worked out. Depends on pcpa_pkg.
module pcpa_front
    import pcpa_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic [ADDR_W-1:0]    region_start,
    input  logic [ADDR_W-1:0]    region_end,
    input  fifo_stat_t           fifo_stat,
    output logic                 fifo_push,
    output cmd_t                 fifo_cmd
);

    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] diff;
    logic              aligned;
    logic              in_region;
    logic              in_table;

    assign addr = s_tdata[CPU_W +: ADDR_W];
    assign base = {region_start[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign diff = addr - base;

    assign aligned   = (addr[PAGE_SHIFT-1:0] == '0);
    assign in_region = (addr >= region_start) && (addr < region_end);
    assign in_table  = ((diff >> PAGE_SHIFT) < ADDR_W'(NUM_PAGES));

    assign s_tready  = !fifo_stat.full;
    assign fifo_push = s_tvalid && !fifo_stat.full;

    always_comb
    begin
        fifo_cmd.cpu  = s_tdata[CPU_W-1:0];
        fifo_cmd.page = diff[PAGE_SHIFT +: PAGE_W];
        if (s_tuser == REQ_ALLOC)
        begin
            fifo_cmd.kind = CMD_ALLOC;
        end
        else if (aligned && in_region && in_table)
        begin
            fifo_cmd.kind = CMD_FREE;
        end
        else
        begin
            fifo_cmd.kind = CMD_BAD;
        end
    end

endmodule

// File: rtl/pcpa_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on pcpa_pkg for the entry type and depth.
module pcpa_cmd_fifo
    import pcpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       head_cmd,
    output fifo_stat_t stat
);

    cmd_t              entry_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/pcpa_back.sv
// Back end: list heads, next-link table and the steal walk, plus the result
// register. Depends on pcpa_pkg.
module pcpa_back
    import pcpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ADDR_W-1:0]    region_start,
    input  cmd_t                 cmd,
    input  fifo_stat_t           fifo_stat,
    output logic                 fifo_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_granted,
    output logic [ADDR_W-1:0]    res_addr,
    output logic [STAT_W-1:0]    res_status
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_POP_RD   = 4'b0010,
        ST_STEAL    = 4'b0100,
        ST_STEAL_RD = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CPU_W-1:0]    cpu_reg, cpu_next;
    logic [VIC_W-1:0]    vic_reg, vic_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [CODE_W-1:0]   chain_reg, chain_next;
    logic [CODE_W-1:0]   link_reg, link_next;
    logic [CODE_W-1:0]   head_reg [NUM_CPUS];

    logic                res_valid_reg;
    logic                res_granted_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STAT_W-1:0]   res_status_reg;

    logic [CODE_W-1:0]   link_mem [NUM_PAGES];
    logic [CODE_W-1:0]   mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [PAGE_W-1:0]   mem_addr;
    logic [CODE_W-1:0]   mem_wdata;

    logic [CPU_W-1:0]    head_ridx;
    logic [CODE_W-1:0]   head_rd;
    logic                head_we;
    logic [CPU_W-1:0]    head_widx;
    logic [CODE_W-1:0]   head_wdata;

    logic                out_free;
    logic                res_load;
    logic                res_granted_d;
    logic [STAT_W-1:0]   res_status_d;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   chain_addr;
    logic [PAGE_W-1:0]   chain_idx;

    assign out_free   = !res_valid_reg || res_ready;
    assign head_ridx  = (state_reg == ST_IDLE) ? cmd.cpu : vic_reg[CPU_W-1:0];
    assign head_rd    = head_reg[head_ridx];
    assign base       = {region_start[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign chain_idx  = PAGE_W'(chain_reg - 1'b1);
    assign chain_addr = base + (ADDR_W'(chain_idx) << PAGE_SHIFT);

    always_comb
    begin
        state_next    = state_reg;
        cpu_next      = cpu_reg;
        vic_next      = vic_reg;
        budget_next   = budget_reg;
        chain_next    = chain_reg;
        link_next     = link_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = '0;
        mem_wdata     = '0;
        head_we       = 1'b0;
        head_widx     = cpu_reg;
        head_wdata    = '0;
        fifo_pop      = 1'b0;
        res_load      = 1'b0;
        res_granted_d = 1'b0;
        res_status_d  = STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_stat.empty && out_free)
                begin
                    fifo_pop = 1'b1;
                    cpu_next = cmd.cpu;
                    unique case (cmd.kind)
                        CMD_ALLOC:
                        begin
                            if (head_rd != '0)
                            begin
                                chain_next = head_rd;
                                mem_re     = 1'b1;
                                mem_addr   = PAGE_W'(head_rd - 1'b1);
                                state_next = ST_POP_RD;
                            end
                            else
                            begin
                                vic_next    = '0;
                                budget_next = BUDGET_W'(STEAL_LIMIT);
                                chain_next  = '0;
                                link_next   = '0;
                                state_next  = ST_STEAL;
                            end
                        end
                        CMD_FREE:
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = cmd.page;
                            mem_wdata  = head_rd;
                            head_we    = 1'b1;
                            head_widx  = cmd.cpu;
                            head_wdata = CODE_W'(cmd.page) + 1'b1;
                            res_load   = 1'b1;
                        end
                        default:
                        begin
                            res_load     = 1'b1;
                            res_status_d = STAT_BAD;
                        end
                    endcase
                end
            end
            ST_POP_RD:
            begin
                head_we       = 1'b1;
                head_wdata    = mem_rdata_reg;
                res_load      = 1'b1;
                res_granted_d = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_STEAL:
            begin
                if ((budget_reg == '0) || (vic_reg == VIC_W'(NUM_CPUS)))
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (chain_reg == '0)
                    begin
                        res_status_d = STAT_OOM;
                    end
                    else
                    begin
                        // newest page's link is the previous chain head
                        head_we       = 1'b1;
                        head_wdata    = link_reg;
                        res_granted_d = 1'b1;
                    end
                end
                else if ((vic_reg[CPU_W-1:0] == cpu_reg) || (head_rd == '0))
                begin
                    vic_next = vic_reg + 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_addr   = PAGE_W'(head_rd - 1'b1);
                    state_next = ST_STEAL_RD;
                end
            end
            ST_STEAL_RD:
            begin
                head_we     = 1'b1;
                head_widx   = vic_reg[CPU_W-1:0];
                head_wdata  = mem_rdata_reg;
                mem_we      = 1'b1;
                mem_addr    = PAGE_W'(head_rd - 1'b1);
                mem_wdata   = chain_reg;
                link_next   = chain_reg;
                chain_next  = head_rd;
                budget_next = budget_reg - 1'b1;
                state_next  = ST_STEAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            budget_reg    <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            budget_reg <= budget_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (head_we)
            begin
                head_reg[head_widx] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cpu_reg   <= cpu_next;
        vic_reg   <= vic_next;
        chain_reg <= chain_next;
        link_reg  <= link_next;
        if (res_load)
        begin
            res_granted_reg <= res_granted_d;
            res_status_reg  <= res_status_d;
            res_addr_reg    <= res_granted_d ? chain_addr : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= link_mem[mem_addr];
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_granted = res_granted_reg;
    assign res_addr    = res_addr_reg;
    assign res_status  = res_status_reg;

`ifndef SYNTHESIS
    a_steal_rd_after_steal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEAL_RD) |-> ($past(state_reg) == ST_STEAL))
        else $error("steal read without steal step");

    a_budget_bound: assert property (@(posedge clk) disable iff (!rst_n)
        budget_reg <= BUDGET_W'(STEAL_LIMIT))
        else $error("steal budget above limit");

    a_busy_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !res_valid_reg)
        else $error("result pending while a command is in progress");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> ((state_reg == ST_IDLE) && !fifo_stat.empty && out_free))
        else $error("command taken while busy or queue empty");
`endif

endmodule

// File: verif/pcpa_tb_pkg.sv
// Scoreboard for the per-CPU page allocator bench: a predictor of the per-CPU
// free lists and link table, and the queue of replies still due.
// Depends on pcpa_pkg.
package pcpa_tb_pkg;

    import pcpa_pkg::*;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } page_reply_t;

    class page_list_scoreboard;

        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
        // 0 = end of list / empty, else page index + 1
        logic [CODE_W-1:0] link_tab [NUM_PAGES];
        logic [CODE_W-1:0] head_tab [NUM_CPUS];
        page_reply_t       replies_due [$];

        int errors;
        int n_req;
        int n_grant;
        int n_oom;
        int n_bad;
        int n_steal;
        int max_steal;

        function new();
            region_start = 32'h8000_0000;
            region_end   = 32'h8800_0000;
            foreach (link_tab[i])
                link_tab[i] = '0;
            foreach (head_tab[i])
                head_tab[i] = '0;
            errors    = 0;
            n_req     = 0;
            n_grant   = 0;
            n_oom     = 0;
            n_bad     = 0;
            n_steal   = 0;
            max_steal = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [ADDR_W-1:0] val);
            if (idx == REG_REGION_START)
                region_start = val;
            else
                region_end = val;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic [CODE_W-1:0] next_of(logic [CODE_W-1:0] code);
            if (code == '0 || int'(code) > NUM_PAGES)
                return '0;
            return link_tab[code - 1'b1];
        endfunction

        function void relink(logic [CODE_W-1:0] code, logic [CODE_W-1:0] val);
            if (code != '0 && int'(code) <= NUM_PAGES)
                link_tab[code - 1'b1] = val;
        endfunction

        function void note_request(logic [0:0] req, logic [CPU_W-1:0] cpu_raw,
                                   logic [ADDR_W-1:0] addr);
            page_reply_t       r;
            int                cpu;
            int                budget;
            int                moved;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W-1:0] offs;
            logic [CODE_W-1:0] chain;
            logic [CODE_W-1:0] pg;
            r.granted = 1'b0;
            r.addr    = '0;
            r.status  = STAT_OK;
            cpu  = int'(cpu_raw) % NUM_CPUS;
            base = region_start & ~ADDR_W'((1 << PAGE_SHIFT) - 1);
            n_req++;
            if (req == REQ_FREE)
            begin
                if (addr[PAGE_SHIFT-1:0] != '0 || addr < region_start || addr >= region_end)
                    r.status = STAT_BAD;
                else
                begin
                    offs = (addr - base) >> PAGE_SHIFT;
                    if (offs >= NUM_PAGES)
                        r.status = STAT_BAD;
                    else
                    begin
                        link_tab[offs] = head_tab[cpu];
                        head_tab[cpu]  = CODE_W'(offs + 1);
                    end
                end
                if (r.status == STAT_BAD)
                    n_bad++;
            end
            else
            begin
                chain = head_tab[cpu];
                if (chain == '0)
                begin
                    // own list empty: pull pages from the others, newest first
                    budget = STEAL_LIMIT;
                    moved  = 0;
                    for (int v = 0; v < NUM_CPUS && budget != 0; v++)
                    begin
                        if (v == cpu)
                            continue;
                        while (head_tab[v] != '0 && budget != 0)
                        begin
                            pg          = head_tab[v];
                            head_tab[v] = next_of(pg);
                            relink(pg, chain);
                            chain = pg;
                            budget--;
                            moved++;
                        end
                    end
                    if (moved != 0)
                        n_steal++;
                    if (moved > max_steal)
                        max_steal = moved;
                end
                if (chain == '0)
                begin
                    r.status = STAT_OOM;
                    n_oom++;
                end
                else
                begin
                    head_tab[cpu] = next_of(chain);
                    r.granted     = 1'b1;
                    r.addr        = base + (ADDR_W'(chain - 1'b1) << PAGE_SHIFT);
                    n_grant++;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic granted, logic [ADDR_W-1:0] addr,
                                  logic [STAT_W-1:0] status);
            page_reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none due: granted %0d addr %h status %0d",
                         $time, granted, addr, status);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (granted !== want.granted)
            begin
                $display("%0t: granted expected %0d actual %0d", $time, want.granted, granted);
                errors++;
            end
            if (addr !== want.addr)
            begin
                $display("%0t: alloc_addr expected %h actual %h", $time, want.addr, addr);
                errors++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
        endfunction

    endclass

endpackage

// File: verif/per_cpu_page_free_list_allocator_top_tb.sv
// Bench for the per-CPU page allocator: directed and random alloc/free words
// under several region settings, random idling on both streams, replies checked
// against the scoreboard. Depends on pcpa_pkg, pcpa_tb_pkg and the top level.
module per_cpu_page_free_list_allocator_top_tb;

    import pcpa_pkg::*;
    import pcpa_tb_pkg::*;

    localparam int LIMIT      = 800000;
    localparam int LAT_CYCLES = NUM_CPUS + 2 * STEAL_LIMIT + 16;
    localparam logic [ADDR_W-1:0] PMASK = ADDR_W'((1 << PAGE_SHIFT) - 1);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    page_list_scoreboard  sb;
    logic [ADDR_W-1:0]    handed_out [$];
    bit                   calm      = 1'b0;
    int                   hold_left = 0;
    int                   cycles    = 0;

    per_cpu_page_free_list_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("per_cpu_page_free_list_allocator_top_tb NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 13);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_reply(m_tuser[0], m_tdata[ADDR_W-1:0],
                           m_tdata[ADDR_W+STAT_W-1:ADDR_W]);
            if (m_tuser[0] && handed_out.size() < 64)
                handed_out.push_back(m_tdata[ADDR_W-1:0]);
        end
    end

    task automatic send_word(logic [0:0] req, logic [CPU_W-1:0] cpu,
                             logic [ADDR_W-1:0] addr, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({addr, cpu});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(req, cpu, addr);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // writes the region registers only once the block is idle
    task automatic set_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        drain_replies();
        repeat (LAT_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REGION_START;
        cfg_data  <= lo;
        @(posedge clk);
        sb.write_reg(REG_REGION_START, lo);
        cfg_index <= REG_REGION_END;
        cfg_data  <= hi;
        @(posedge clk);
        sb.write_reg(REG_REGION_END, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_good_addr(output bit found);
        logic [63:0] mask;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] n;
        int          span;
        mask  = (64'd1 << PAGE_SHIFT) - 1;
        lo    = ({32'h0, sb.region_start} + mask) & ~mask;
        hi    = ({32'h0, sb.region_start} & ~mask) + (64'(NUM_PAGES) << PAGE_SHIFT);
        if ({32'h0, sb.region_end} < hi)
            hi = {32'h0, sb.region_end};
        found = lo < hi;
        if (!found)
            return '0;
        n    = (hi - lo + mask) >> PAGE_SHIFT;
        span = (n > 96 && $urandom_range(0, 7) != 0) ? 96 : int'(n);
        return ADDR_W'(lo + (64'($urandom_range(0, span - 1)) << PAGE_SHIFT));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_odd_addr();
        logic [ADDR_W-1:0] a;
        bit                found;
        case ($urandom_range(0, 4))
            0: a = $urandom;
            1:
            begin
                a = pick_good_addr(found);
                a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
            end
            2: a = sb.region_end;
            3: a = sb.region_start - (ADDR_W'(1) << PAGE_SHIFT);
            default: a = ADDR_W'($urandom) & ~PMASK;
        endcase
        return a;
    endfunction

    // hog >= 0: allocs mostly from that CPU, frees to the others, to force steals
    task automatic run_random(int count, int hog, int alloc_pct);
        int                r;
        int                cpu;
        int                gap;
        int                k;
        logic [0:0]        req;
        logic [ADDR_W-1:0] addr;
        bit                found;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 149) == 0)
                drain_replies();
            gap  = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
            r    = $urandom_range(0, 99);
            cpu  = $urandom_range(0, NUM_CPUS - 1);
            addr = $urandom;
            if (r < alloc_pct)
            begin
                req = REQ_ALLOC;
                if (hog >= 0 && $urandom_range(0, 3) != 0)
                    cpu = hog;
            end
            else
            begin
                req = REQ_FREE;
                if (hog >= 0 && cpu == hog)
                    cpu = (hog + 1 + $urandom_range(0, NUM_CPUS - 2)) % NUM_CPUS;
                if (r < alloc_pct + 12)
                    addr = pick_odd_addr();
                else if (handed_out.size() != 0 && $urandom_range(0, 2) == 0)
                begin
                    k    = $urandom_range(0, handed_out.size() - 1);
                    addr = handed_out[k];
                    handed_out.delete(k);
                end
                else
                begin
                    addr = pick_good_addr(found);
                    if (!found)
                        addr = $urandom;
                end
            end
            send_word(req, CPU_W'(cpu), addr, gap);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset region: empty list, edges of the region, bad frees, steal, double free
        send_word(REQ_ALLOC, 3'd0, 32'h0000_0000, 0);
        send_word(REQ_FREE,  3'd0, 32'h8000_0000, 0);
        send_word(REQ_FREE,  3'd7, 32'h87FF_F000, 0);
        send_word(REQ_FREE,  3'd1, 32'h8800_0000, 0);
        send_word(REQ_FREE,  3'd1, 32'h7FFF_F000, 0);
        send_word(REQ_FREE,  3'd2, 32'h8000_0800, 0);
        send_word(REQ_FREE,  3'd3, 32'hFFFF_FFFF, 0);
        send_word(REQ_FREE,  3'd4, 32'h0000_0000, 0);
        send_word(REQ_ALLOC, 3'd0, 32'hFFFF_FFFF, 0);
        send_word(REQ_ALLOC, 3'd0, 32'h0000_0000, 0);
        send_word(REQ_ALLOC, 3'd0, 32'h0000_0000, 0);
        send_word(REQ_FREE,  3'd5, 32'h8000_1000, 0);
        send_word(REQ_FREE,  3'd5, 32'h8000_1000, 0);
        send_word(REQ_ALLOC, 3'd5, 32'h0000_0000, 0);
        send_word(REQ_ALLOC, 3'd5, 32'h0000_0000, 0);

        // whole address space: index past the link table is a bad free
        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(REQ_FREE,  3'd6, 32'h0800_0000, 0);
        send_word(REQ_FREE,  3'd6, 32'h07FF_F000, 0);
        send_word(REQ_FREE,  3'd6, 32'h0000_0000, 0);
        send_word(REQ_ALLOC, 3'd6, 32'h0000_0000, 0);
        send_word(REQ_ALLOC, 3'd2, 32'h0000_0000, 0);
        run_random(170, 0, 40);

        // tiny region with unaligned start
        set_region(32'h0000_1001, 32'h0002_0000);
        run_random(150, -1, 45);

        // one page at the top; listed pages relocate and wrap
        set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
        run_random(130, -1, 50);

        // empty region
        set_region(32'hFFFF_FFFF, 32'h0000_0000);
        run_random(60, -1, 40);

        set_region(32'h8000_0000, 32'h8800_0000);
        run_random(120, 3, 45);
        calm = 1'b1;
        run_random(170, -1, 45);

        drain_replies();
        repeat (LAT_CYCLES) @(posedge clk);
        $display("%0d words over 6 region settings: %0d grants, %0d out of memory, %0d bad frees",
                 sb.n_req, sb.n_grant, sb.n_oom, sb.n_bad);
        $display("%0d steals, largest %0d pages, %0d mismatches",
                 sb.n_steal, sb.max_steal, sb.errors);
        if (sb.errors == 0)
            $display("per_cpu_page_free_list_allocator_top_tb OK");
        else
            $display("per_cpu_page_free_list_allocator_top_tb NOT OK");
        $finish;
    end

endmodule
